// ----- rtl/key_value_table_fifo_evict_assert.svh -----
// Assertion macros for the key/value table.
// Expects signals clk and rst in the including scope.
`ifndef KEY_VALUE_TABLE_FIFO_EVICT_ASSERT_SVH
`define KEY_VALUE_TABLE_FIFO_EVICT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KVTFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvtfe assertion failed");

// Next-cycle implication, checked outside reset.
`define KVTFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvtfe assertion failed");

`endif

// ----- rtl/kvtfe_pkg.sv -----
// Shared types and constants for the key/value table.
// No dependencies.
package kvtfe_pkg;

  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_STORE  = 1'b1;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               cmp_en;
    logic [KEY_W-1:0]   cmp_key;
    logic               upd_hit;
    logic               fill;
    logic               shift;
    logic [KEY_W-1:0]   wr_key;
    logic [VALUE_W-1:0] wr_value;
  } cell_ctrl_t;

endpackage

// ----- rtl/kvtfe_cell.sv -----
// One slot of the table: key, value, valid and a registered key match.
// Depends on kvtfe_pkg.
module kvtfe_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  kvtfe_pkg::cell_ctrl_t        ctrl,
  input  logic                         prev_valid,
  input  logic [kvtfe_pkg::KEY_W-1:0]  next_key,
  input  logic [kvtfe_pkg::VALUE_W-1:0] next_value,
  output logic                         valid,
  output logic [kvtfe_pkg::KEY_W-1:0]  key,
  output logic [kvtfe_pkg::VALUE_W-1:0] value,
  output logic                         match,
  output logic [kvtfe_pkg::VALUE_W-1:0] hit_value
);

  logic fill_here;

  // Slots are packed, so the first empty slot is the one after the last full one.
  assign fill_here = ctrl.fill && !valid && prev_valid;
  assign hit_value = match ? value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match <= valid && (key == ctrl.cmp_key);
      end
      if (fill_here) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd_hit && match) begin
      value <= ctrl.wr_value;
    end else if (fill_here) begin
      key   <= ctrl.wr_key;
      value <= ctrl.wr_value;
    end else if (ctrl.shift) begin
      key   <= next_key;
      value <= next_value;
    end
  end

endmodule

// ----- rtl/key_value_table_fifo_evict.sv -----
// Key/value table with oldest-first eviction, built as a row of slot cells.
// Depends on kvtfe_pkg, kvtfe_cell and key_value_table_fifo_evict_assert.svh.
//
// Input words arrive on s_tvalid/s_tready/s_tdata: a lookup (func 0) or a
// store (func 1) of a 32-bit key and value. A lookup returns one word on
// m_tvalid/m_tready/m_tdata with found and the stored value (zero on a
// miss). A store returns nothing; a store with key zero is dropped.
// A store to a present key updates it in place, otherwise it fills the next
// free slot; on a full table every cell takes its upper neighbor's pair,
// the oldest pair falls out of slot 0 and the new pair enters the top slot.
//
// Each word passes through ST_IDLE and ST_APPLY: the accept edge registers
// the key compare in every cell; in ST_APPLY the cell matches are ORed and
// the edge leaving ST_APPLY applies the update or loads the result register.
// While a result waits, the next word is still accepted; a following lookup
// holds in ST_APPLY until the output register frees up.
// Reset empties the table and drops any pending result.
module key_value_table_fifo_evict #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // func[0], key[32:1], value[64:33], zero pad[71:65]
  input  logic [kvtfe_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // found[0], result_value[32:1], zero pad[39:33]
  output logic [kvtfe_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  `include "key_value_table_fifo_evict_assert.svh"

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  state_t                           state;
  logic                             op_func;
  logic [kvtfe_pkg::KEY_W-1:0]      op_key;
  logic [kvtfe_pkg::VALUE_W-1:0]    op_value;
  logic                             out_found;
  logic [kvtfe_pkg::VALUE_W-1:0]    out_value;

  kvtfe_pkg::cell_ctrl_t            ctrl;
  logic [TABLE_DEPTH-1:0]           cell_valid;
  logic [TABLE_DEPTH-1:0]           cell_match;
  logic [kvtfe_pkg::KEY_W-1:0]      cell_key   [TABLE_DEPTH];
  logic [kvtfe_pkg::VALUE_W-1:0]    cell_value [TABLE_DEPTH];
  logic [kvtfe_pkg::VALUE_W-1:0]    cell_hitv  [TABLE_DEPTH];
  logic [kvtfe_pkg::KEY_W-1:0]      nxt_key    [TABLE_DEPTH];
  logic [kvtfe_pkg::VALUE_W-1:0]    nxt_value  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]           prv_valid;

  logic                             accept;
  logic                             hit_any;
  logic [kvtfe_pkg::VALUE_W-1:0]    hit_value;
  logic                             store_go;
  logic                             out_free;
  logic                             out_load;
  logic [TABLE_DEPTH:0]             valid_inc;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_APPLY) && (op_func == kvtfe_pkg::FUNC_LOOKUP) && out_free;
  assign m_tdata  = {{(kvtfe_pkg::OUT_TDATA_W - kvtfe_pkg::VALUE_W - 1){1'b0}},
                     out_value, out_found};

  // Keys are unique in the table, so at most one cell contributes.
  assign hit_any = |cell_match;
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_value = hit_value | cell_hitv[i];
    end
  end

  assign store_go = (state == ST_APPLY) && (op_func == kvtfe_pkg::FUNC_STORE) &&
                    (op_key != '0);

  always_comb begin
    ctrl.cmp_en   = accept;
    ctrl.cmp_key  = s_tdata[kvtfe_pkg::KEY_W:1];
    ctrl.upd_hit  = store_go && hit_any;
    ctrl.fill     = store_go && !hit_any && !cell_valid[TABLE_DEPTH-1];
    ctrl.shift    = store_go && !hit_any && cell_valid[TABLE_DEPTH-1];
    ctrl.wr_key   = op_key;
    ctrl.wr_value = op_value;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prv_valid[i] = 1'b1;
    end else begin : g_rest
      assign prv_valid[i] = cell_valid[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nxt_key[i]   = op_key;
      assign nxt_value[i] = op_value;
    end else begin : g_mid
      assign nxt_key[i]   = cell_key[i+1];
      assign nxt_value[i] = cell_value[i+1];
    end

    kvtfe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prv_valid[i]),
      .next_key   (nxt_key[i]),
      .next_value (nxt_value[i]),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .match      (cell_match[i]),
      .hit_value  (cell_hitv[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_func  <= s_tdata[0];
            op_key   <= s_tdata[kvtfe_pkg::KEY_W:1];
            op_value <= s_tdata[kvtfe_pkg::KEY_W+kvtfe_pkg::VALUE_W:kvtfe_pkg::KEY_W+1];
            state    <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (op_func == kvtfe_pkg::FUNC_STORE) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_found <= hit_any;
            out_value <= hit_value;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Occupied slots form a run from slot 0 upward.
  assign valid_inc = {1'b0, cell_valid} + (TABLE_DEPTH + 1)'(1);

  `KVTFE_ASSERT_IMPL(a_single_match, state == ST_APPLY, $onehot0(cell_match))
  `KVTFE_ASSERT_IMPL(a_packed_slots, 1'b1, $onehot(valid_inc))
  `KVTFE_ASSERT_IMPL(a_miss_zero, m_tvalid && !out_found, out_value == '0)
  `KVTFE_ASSERT_NEXT(a_accept_apply, accept, state == ST_APPLY)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for key_value_table_fifo_evict: directed and random
// lookups/stores checked against a behavioral table. Needs kvtfe_pkg and the RTL.
module tb_top;

  localparam int DEPTH          = 32;
  localparam int POOL_SIZE      = 64;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int IDLE_PCT       = 38;
  localparam int QUIET_FROM     = 300;
  localparam int QUIET_TO       = 500;

  typedef struct packed {
    logic                          func;
    logic [kvtfe_pkg::KEY_W-1:0]   key;
    logic [kvtfe_pkg::VALUE_W-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic                          found;
    logic [kvtfe_pkg::VALUE_W-1:0] value;
  } lookup_reply_t;

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [kvtfe_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [kvtfe_pkg::OUT_TDATA_W-1:0] m_tdata;

  table_op_t     op_queue[$];
  lookup_reply_t reply_queue[$];

  logic [kvtfe_pkg::KEY_W-1:0]   table_keys   [DEPTH];
  logic [kvtfe_pkg::VALUE_W-1:0] table_values [DEPTH];
  int                            table_fill = 0;
  logic [kvtfe_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];

  int err_count    = 0;
  int ops_accepted = 0;
  int stall_cycles = 0;

  key_value_table_fifo_evict #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Random idling, switched off for a stretch in the middle of the run.
  function automatic bit idle_roll();
    if (ops_accepted >= QUIET_FROM && ops_accepted < QUIET_TO)
      return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Behavioral table: lookups queue their expected reply, stores update state.
  task automatic lookup_or_store(input table_op_t op);
    int            slot;
    lookup_reply_t reply;
    slot = -1;
    if (op.key != '0) begin
      for (int i = 0; i < table_fill; i++)
        if (slot < 0 && table_keys[i] == op.key)
          slot = i;
    end
    if (op.func == kvtfe_pkg::FUNC_LOOKUP) begin
      reply.found = (slot >= 0);
      reply.value = (slot >= 0) ? table_values[slot] : '0;
      reply_queue.push_back(reply);
    end else if (op.key != '0) begin
      if (slot >= 0) begin
        table_values[slot] = op.value;
      end else if (table_fill < DEPTH) begin
        table_keys[table_fill]   = op.key;
        table_values[table_fill] = op.value;
        table_fill++;
      end else begin
        // full: oldest pair drops out of slot 0
        for (int i = 0; i < DEPTH - 1; i++) begin
          table_keys[i]   = table_keys[i+1];
          table_values[i] = table_values[i+1];
        end
        table_keys[DEPTH-1]   = op.key;
        table_values[DEPTH-1] = op.value;
      end
    end
  endtask

  task automatic add_op(input logic func, input logic [kvtfe_pkg::KEY_W-1:0] key,
                        input logic [kvtfe_pkg::VALUE_W-1:0] value);
    table_op_t op;
    op.func  = func;
    op.key   = key;
    op.value = value;
    op_queue.push_back(op);
  endtask

  // Driver: hold the word until accepted, then pull the next one or idle.
  always @(posedge clk) begin : driver
    table_op_t next_op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (op_queue.size() > 0 && !idle_roll()) begin
        next_op = op_queue.pop_front();
        s_tdata  <= kvtfe_pkg::IN_TDATA_W'({next_op.value, next_op.key, next_op.func});
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= !idle_roll();
  end

  // Monitor: predict on input accept, check each output word in order.
  always @(posedge clk) begin : monitor
    table_op_t     op;
    lookup_reply_t got;
    lookup_reply_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.found = m_tdata[0];
        got.value = m_tdata[32:1];
        if (reply_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word found=%0b value=%h",
                                    got.found, got.value));
        end else begin
          want = reply_queue.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found: got %0b want %0b", got.found, want.found));
          if (got.value !== want.value)
            report_mismatch($sformatf("result_value: got %h want %h",
                                      got.value, want.value));
        end
      end
      if (s_tvalid && s_tready) begin
        op.func  = s_tdata[0];
        op.key   = s_tdata[32:1];
        op.value = s_tdata[64:33];
        lookup_or_store(op);
        ops_accepted++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no words moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    table_op_t op;
    int        pool_n;
    int        store_pct;
    int        roll;
    for (int i = 0; i < DEPTH; i++) begin
      table_keys[i]   = '0;
      table_values[i] = '0;
    end
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0)
        key_pool[i] = 32'h0000_1234;
    end

    // directed: key zero, empty table, zero value hit, update, extreme fields
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h0000_0005, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'h0000_0000, 32'hDEAD_BEEF);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'h0000_0001, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF);
    add_op(kvtfe_pkg::FUNC_STORE,  32'h0000_0001, 32'h1234_5678);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'h8000_0000, 32'h0000_0001);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'h0000_0000, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(kvtfe_pkg::FUNC_STORE,  32'hFFFF_FFFF, 32'hA5A5_5A5A);
    add_op(kvtfe_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

    // random phases; the larger key pools overflow the table and force evictions
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin pool_n = 8;         store_pct = 40; end
        1: begin pool_n = 40;        store_pct = 60; end
        2: begin pool_n = POOL_SIZE; store_pct = 70; end
        default: begin pool_n = 24;  store_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll    = $urandom_range(0, 99);
        op.func = ($urandom_range(0, 99) < store_pct) ? kvtfe_pkg::FUNC_STORE
                                                      : kvtfe_pkg::FUNC_LOOKUP;
        if (roll < 3)
          op.key = '0;
        else if (roll < 8)
          op.key = $urandom;
        else
          op.key = key_pool[$urandom_range(0, pool_n - 1)];
        op.value = $urandom;
        op_queue.push_back(op);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || s_tvalid || reply_queue.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
